[src/rrts_pkg.sv]
// Shared types and constants for the round-robin task scheduler.
// Used by every module of the block except rrts_ram; depends on nothing else.
package rrts_pkg;

    // Default size of the task table.
    localparam int MAX_TASKS_DEF = 16;

    // Fixed field widths.
    localparam int OPCODE_W = 2;
    localparam int SLEEP_W  = 32;
    localparam int TICK_W   = 64;
    localparam int TASK_W   = 4;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Register map of the configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_SCHED_ENABLE = 1'b0;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SLEEP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd2;

    // Classified item kind as it travels to the back end.
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SLEEP,
        KIND_ADD,
        KIND_NONE
    } op_kind_t;

    // Input item.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SLEEP_W-1:0]  sleep_ms;
    } cmd_t;

    // Result item.
    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              switched;
        logic              add_full;
    } result_t;

    // Entry of the queue between front and back.
    typedef struct packed {
        op_kind_t           kind;
        logic [SLEEP_W-1:0] sleep_ms;
    } qentry_t;

endpackage

[src/round_robin_task_scheduler.sv]
// Usage
// -----
// Round-robin task selector with timed sleep. Input items (tick, sleep,
// add-task) are pushed into a queue-like port: an item is taken when push is
// high and full is low. Each item produces exactly one result item, shown on
// task_result while empty is low and taken when pop is high.
// A front end classifies items into a two-entry queue; a back end executes
// them one at a time and scans the task ring one slot per cycle, reading
// the wake times from a RAM with registered read data.
// Sequence: an add-task or an unscheduled item passes from the queue through
// the states S_IDLE, S_EXEC and S_DONE to the result register; a scheduling
// item also passes through S_SCAN, which visits at most the task count of
// slots. The back end takes the next item only once it is back in S_IDLE, so
// the ring scan sets the throughput of tick and sleep items.
// Reset leaves one runnable main task in slot 0, the tick counter at zero,
// scheduling enabled and both queues empty. When the receiver holds off pop,
// the result waits in its register, the back end stalls after its next item,
// and full rises once the front queue holds two items.
// The sched_enable register sits at byte address 0 of the APB port.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cmd_t                  task_cmd,
    output logic                  empty,
    input  logic                  pop,
    output result_t               task_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    sched_enable_reg, sched_enable_next;
    logic    q_valid;
    qentry_t q_item;
    logic    q_pop;
    logic    cfg_write;
    logic    reg_sel;

    // Configuration register.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[CFG_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        sched_enable_next = sched_enable_reg;
        if (cfg_write && (reg_sel == REG_SCHED_ENABLE))
        begin
            sched_enable_next = pwdata[0];
        end
    end

    assign prdata = (reg_sel == REG_SCHED_ENABLE) ?
                    CFG_DATA_W'(sched_enable_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_enable_reg <= 1'b1;
        end
        else
        begin
            sched_enable_reg <= sched_enable_next;
        end
    end

    // Front end: accept and classify items.
    rrts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .task_cmd (task_cmd),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back end: execute items and deliver results.
    rrts_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sched_enable (sched_enable_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .task_result  (task_result)
    );

endmodule

[src/rrts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module rrts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rrts_front.sv]
// Front end: accepts input items, classifies the opcode and queues them.
// Depends on rrts_pkg.
module rrts_front
    import rrts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  cmd_t    task_cmd,
    output logic    q_valid,
    output qentry_t q_item,
    input  logic    q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t          entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    qentry_t          classified;
    logic             do_push;
    logic             do_pop;

    // Classify the opcode; the unused code becomes a no-op item.
    always_comb
    begin
        classified.sleep_ms = task_cmd.sleep_ms;
        case (task_cmd.opcode)
            OP_TICK:  classified.kind = KIND_TICK;
            OP_SLEEP: classified.kind = KIND_SLEEP;
            OP_ADD:   classified.kind = KIND_ADD;
            default:  classified.kind = KIND_NONE;
        endcase
    end

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[src/rrts_back.sv]
// Back end: executes queued items, scans the task ring and holds the result.
// Depends on rrts_pkg and rrts_ram.
module rrts_back
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sched_enable,
    input  logic    q_valid,
    input  qentry_t q_item,
    output logic    q_pop,
    output logic    empty,
    input  logic    pop,
    output result_t task_result
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    op_kind_t               kind_reg, kind_next;
    logic [SLEEP_W-1:0]     delay_reg, delay_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MAX_TASKS-1:0]   sleeping_reg, sleeping_next;
    logic [SLOT_W-1:0]      scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic [SLOT_W-1:0]      pipe_slot_reg, pipe_slot_next;
    logic                   pipe_sleep_reg, pipe_sleep_next;
    logic                   res_sw_reg, res_sw_next;
    logic                   res_full_reg, res_full_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic                   wake_we;
    logic [TICK_W-1:0]      wake_wdata;
    logic [TICK_W-1:0]      wake_rdata;
    logic                   hit;
    logic                   scan_req;
    logic [SLOT_W-1:0]      cur_succ;
    logic [SLOT_W-1:0]      scan_succ;

    // Wake times: written by a sleep, read one slot per cycle by the scan.
    rrts_ram #(
        .WIDTH (TICK_W),
        .DEPTH (MAX_TASKS)
    ) u_wake_ram (
        .clk   (clk),
        .we    (wake_we),
        .waddr (cur_reg),
        .wdata (wake_wdata),
        .raddr (scan_slot_reg),
        .rdata (wake_rdata)
    );

    // Ring successors of the current slot and of the scan pointer.
    assign cur_succ  = (CNT_W'(cur_reg) == count_reg - CNT_W'(1)) ?
                       '0 : cur_reg + SLOT_W'(1);
    assign scan_succ = (CNT_W'(scan_slot_reg) == count_reg - CNT_W'(1)) ?
                       '0 : scan_slot_reg + SLOT_W'(1);

    // A slot qualifies when it is runnable or its wake time has passed.
    assign hit = pipe_valid_reg && (!pipe_sleep_reg || (tick_reg > wake_rdata));

    assign wake_wdata  = tick_reg + TICK_W'(delay_reg);
    assign empty       = !out_valid_reg;
    assign task_result = out_reg;

    // Sequencer for one item.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        delay_next      = delay_reg;
        tick_next       = tick_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        sleeping_next   = sleeping_reg;
        scan_slot_next  = scan_slot_reg;
        issue_cnt_next  = issue_cnt_reg;
        pipe_valid_next = 1'b0;
        pipe_slot_next  = pipe_slot_reg;
        pipe_sleep_next = pipe_sleep_reg;
        res_sw_next     = res_sw_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_next        = out_reg;
        q_pop           = 1'b0;
        wake_we         = 1'b0;
        scan_req        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_item.kind;
                    delay_next = q_item.sleep_ms;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_full_next = 1'b0;
                res_sw_next   = 1'b0;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        tick_next = tick_reg + TICK_W'(1);
                        scan_req  = 1'b1;
                    end
                    KIND_SLEEP:
                    begin
                        sleeping_next[cur_reg] = 1'b1;
                        wake_we                = 1'b1;
                        scan_req               = 1'b1;
                    end
                    KIND_ADD:
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            sleeping_next[count_reg[SLOT_W-1:0]] = 1'b0;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (scan_req && sched_enable && (count_reg > CNT_W'(1)))
                begin
                    scan_slot_next = cur_succ;
                    issue_cnt_next = '0;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN:
            begin
                // Issue one slot per cycle; its wake time arrives next cycle.
                if (issue_cnt_reg != count_reg)
                begin
                    pipe_valid_next = 1'b1;
                    pipe_slot_next  = scan_slot_reg;
                    pipe_sleep_next = sleeping_reg[scan_slot_reg];
                    scan_slot_next  = scan_succ;
                    issue_cnt_next  = issue_cnt_reg + CNT_W'(1);
                end
                // Check the slot issued last cycle.
                if (hit)
                begin
                    cur_next                      = pipe_slot_reg;
                    sleeping_next[pipe_slot_reg]  = 1'b0;
                    res_sw_next                   = 1'b1;
                    pipe_valid_next               = 1'b0;
                    state_next                    = S_DONE;
                end
                else if (pipe_valid_reg && (issue_cnt_reg == count_reg))
                begin
                    // The whole ring failed: keep the current task.
                    pipe_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next        = 1'b1;
                    out_next.running_task = TASK_W'(cur_reg);
                    out_next.switched     = res_sw_reg;
                    out_next.add_full     = res_full_reg;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            cur_reg        <= '0;
            count_reg      <= CNT_W'(1);
            sleeping_reg   <= '0;
            issue_cnt_reg  <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            sleeping_reg   <= sleeping_next;
            issue_cnt_reg  <= issue_cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        delay_reg      <= delay_next;
        scan_slot_reg  <= scan_slot_next;
        pipe_slot_reg  <= pipe_slot_next;
        pipe_sleep_reg <= pipe_sleep_next;
        res_sw_reg     <= res_sw_next;
        res_full_reg   <= res_full_next;
        out_reg        <= out_next;
    end

`ifndef NO_ASSERTIONS
    // The running task always lies inside the populated part of the ring.
    a_cur_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(cur_reg) < count_reg)
        else $error("current slot outside the task ring");

    // The task count stays between one and the table size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_TASKS)))
        else $error("task count out of range");

    // A selected task is runnable afterwards.
    a_selected_runnable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && hit |=> !sleeping_reg[cur_reg])
        else $error("selected task still marked sleeping");

    // The scan pipeline only carries slots during a scan.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == S_SCAN))
        else $error("scan pipeline busy outside a scan");

    // A waiting result is never overwritten before it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("waiting result changed");
`endif

endmodule
